>>> rtl/ps2txt_pkg.sv
package ps2txt_pkg;

  localparam int SCAN_W = 8;
  localparam int CHAR_W = 7;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 6;
  localparam int CLIM_W = 8;
  localparam int RLIM_W = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 8;

  localparam logic [CLIM_W-1:0] COL_LIMIT_RST = 8'd80;
  localparam logic [RLIM_W-1:0] ROW_LIMIT_RST = 7'd40;
  localparam logic [CLIM_W-1:0] COL_LIMIT_MAX = 8'd128;
  localparam logic [RLIM_W-1:0] ROW_LIMIT_MAX = 7'd64;

  localparam logic [CFG_IDX_W-1:0] CFG_COL_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LIMIT = 1'd1;

  localparam logic [SCAN_W-1:0] KEY_BREAK  = 8'hF0;
  localparam logic [SCAN_W-1:0] KEY_EXT    = 8'hE0;
  localparam logic [SCAN_W-1:0] KEY_BKSP   = 8'h66;
  localparam logic [SCAN_W-1:0] KEY_ENTER  = 8'h5A;
  localparam logic [SCAN_W-1:0] KEY_CTRL   = 8'h14;
  localparam logic [SCAN_W-1:0] KEY_LSHIFT = 8'h12;
  localparam logic [SCAN_W-1:0] KEY_RSHIFT = 8'h59;
  localparam logic [SCAN_W-1:0] KEY_CAPS   = 8'h58;
  localparam logic [SCAN_W-1:0] KEY_DEL    = 8'h71;
  localparam logic [SCAN_W-1:0] KEY_SPACE  = 8'h29;
  localparam logic [SCAN_W-1:0] KEY_TAB    = 8'h0D;
  localparam logic [SCAN_W-1:0] KEY_ESC    = 8'h76;

  localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 7'h09;
  localparam logic [CHAR_W-1:0] CHAR_ESC   = 7'h1B;
  localparam logic [CHAR_W-1:0] CHAR_DEL   = 7'h7F;
  localparam logic [CHAR_W-1:0] CHAR_UPPER = 7'h41;
  localparam logic [CHAR_W-1:0] CHAR_LOWER = 7'h61;

  typedef struct packed {
    logic             brk;
    logic             ext;
    logic             shl;
    logic             shr;
    logic             ctl;
    logic             ctr;
    logic             caps;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } kb_state_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic [COL_W-1:0]  cursor_column;
    logic [ROW_W-1:0]  cursor_row;
  } text_res_t;

  typedef struct packed {
    logic              hit;
    logic [CHAR_W-1:0] ch;
  } key_map_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] idx;
  } letter_t;

  function automatic letter_t letter_lookup(input logic [SCAN_W-1:0] sc);
    letter_t r;
    r.hit = 1'b1;
    case (sc)
      8'h1C: r.idx = 5'd0;
      8'h32: r.idx = 5'd1;
      8'h21: r.idx = 5'd2;
      8'h23: r.idx = 5'd3;
      8'h24: r.idx = 5'd4;
      8'h2B: r.idx = 5'd5;
      8'h34: r.idx = 5'd6;
      8'h33: r.idx = 5'd7;
      8'h43: r.idx = 5'd8;
      8'h3B: r.idx = 5'd9;
      8'h42: r.idx = 5'd10;
      8'h4B: r.idx = 5'd11;
      8'h3A: r.idx = 5'd12;
      8'h31: r.idx = 5'd13;
      8'h44: r.idx = 5'd14;
      8'h4D: r.idx = 5'd15;
      8'h15: r.idx = 5'd16;
      8'h2D: r.idx = 5'd17;
      8'h1B: r.idx = 5'd18;
      8'h2C: r.idx = 5'd19;
      8'h3C: r.idx = 5'd20;
      8'h2A: r.idx = 5'd21;
      8'h1D: r.idx = 5'd22;
      8'h22: r.idx = 5'd23;
      8'h35: r.idx = 5'd24;
      8'h1A: r.idx = 5'd25;
      default: begin
        r.hit = 1'b0;
        r.idx = 5'd0;
      end
    endcase
    return r;
  endfunction

  function automatic key_map_t symbol_lookup(input logic [SCAN_W-1:0] sc, input logic shift);
    key_map_t r;
    logic [CHAR_W-1:0] p;
    logic [CHAR_W-1:0] s;
    r.hit = 1'b1;
    case (sc)
      8'h45: begin p = 7'h30; s = 7'h29; end
      8'h16: begin p = 7'h31; s = 7'h21; end
      8'h1E: begin p = 7'h32; s = 7'h40; end
      8'h26: begin p = 7'h33; s = 7'h23; end
      8'h25: begin p = 7'h34; s = 7'h24; end
      8'h2E: begin p = 7'h35; s = 7'h25; end
      8'h36: begin p = 7'h36; s = 7'h5E; end
      8'h3D: begin p = 7'h37; s = 7'h26; end
      8'h3E: begin p = 7'h38; s = 7'h2A; end
      8'h46: begin p = 7'h39; s = 7'h28; end
      8'h52: begin p = 7'h27; s = 7'h22; end
      8'h41: begin p = 7'h2C; s = 7'h3C; end
      8'h4E: begin p = 7'h2D; s = 7'h5F; end
      8'h49: begin p = 7'h2E; s = 7'h3E; end
      8'h4A: begin p = 7'h2F; s = 7'h3F; end
      8'h4C: begin p = 7'h3B; s = 7'h3A; end
      8'h55: begin p = 7'h3D; s = 7'h2B; end
      8'h54: begin p = 7'h5B; s = 7'h7B; end
      8'h5D: begin p = 7'h5C; s = 7'h7C; end
      8'h5B: begin p = 7'h5D; s = 7'h7D; end
      8'h0E: begin p = 7'h60; s = 7'h7E; end
      default: begin
        r.hit = 1'b0;
        p = 7'h00;
        s = 7'h00;
      end
    endcase
    r.ch = shift ? s : p;
    return r;
  endfunction

  function automatic key_map_t ctrl_lookup(input logic [SCAN_W-1:0] sc);
    key_map_t r;
    r.hit = 1'b1;
    case (sc)
      8'h1E: r.ch = 7'h00;
      8'h54: r.ch = 7'h1B;
      8'h5D: r.ch = 7'h1C;
      8'h5B: r.ch = 7'h1D;
      8'h36: r.ch = 7'h1E;
      8'h4E: r.ch = 7'h1F;
      8'h4A: r.ch = 7'h7F;
      default: begin
        r.hit = 1'b0;
        r.ch  = 7'h00;
      end
    endcase
    return r;
  endfunction

  function automatic key_map_t map_key(input logic [SCAN_W-1:0] sc, input logic ctrl,
                                       input logic shift, input logic caps, input logic ext);
    key_map_t r;
    letter_t  li;
    key_map_t sy;
    key_map_t cc;
    li = letter_lookup(sc);
    sy = symbol_lookup(sc, shift);
    cc = ctrl_lookup(sc);
    r.hit = 1'b1;
    r.ch  = 7'h00;
    if (ctrl) begin
      if (li.hit) r.ch = {2'b00, li.idx} + 7'd1;
      else r = cc;
    end else if (li.hit) begin
      r.ch = ((shift ^ caps) ? CHAR_UPPER : CHAR_LOWER) + {2'b00, li.idx};
    end else if (sy.hit) begin
      r = sy;
    end else if (sc == KEY_SPACE) begin
      r.ch = CHAR_SPACE;
    end else if (sc == KEY_TAB) begin
      r.ch = CHAR_TAB;
    end else if (sc == KEY_ESC) begin
      r.ch = CHAR_ESC;
    end else if (sc == KEY_DEL && ext) begin
      r.ch = CHAR_DEL;
    end else begin
      r.hit = 1'b0;
    end
    return r;
  endfunction

endpackage

>>> rtl/ps2txt_ifs.sv
interface ps2txt_scan_if;
  logic                         valid;
  logic                         ready;
  logic [ps2txt_pkg::SCAN_W-1:0] scan_code;
  modport source (output valid, output scan_code, input ready);
  modport sink (input valid, input scan_code, output ready);
endinterface

interface ps2txt_text_if;
  logic                         valid;
  logic                         ready;
  logic [ps2txt_pkg::CHAR_W-1:0] character;
  logic [ps2txt_pkg::COL_W-1:0]  cursor_column;
  logic [ps2txt_pkg::ROW_W-1:0]  cursor_row;
  modport source (output valid, output character, output cursor_column, output cursor_row,
                  input ready);
  modport sink (input valid, input character, input cursor_column, input cursor_row,
                output ready);
endinterface

interface ps2txt_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ps2txt_pkg::CFG_IDX_W-1:0] index;
  logic [ps2txt_pkg::CFG_DAT_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/ps2txt_core.sv
module ps2txt_core (
  input  logic [ps2txt_pkg::SCAN_W-1:0] scan_code,
  input  ps2txt_pkg::kb_state_t         st,
  input  logic [ps2txt_pkg::CLIM_W-1:0] col_limit,
  input  logic [ps2txt_pkg::RLIM_W-1:0] row_limit,
  output ps2txt_pkg::kb_state_t         st_nxt,
  output logic                          res_vld,
  output ps2txt_pkg::text_res_t         res
);
  import ps2txt_pkg::*;

  logic              ctrl;
  logic              shift;
  key_map_t          km;
  logic [CLIM_W-1:0] clim;
  logic [RLIM_W-1:0] rlim;
  logic [COL_W:0]    col_w;
  logic [ROW_W:0]    row_w;

  assign ctrl  = st.ctl | st.ctr;
  assign shift = st.shl | st.shr;
  assign km    = map_key(scan_code, ctrl, shift, st.caps, st.ext);
  assign clim  = (col_limit > COL_LIMIT_MAX) ? COL_LIMIT_MAX : col_limit;
  assign rlim  = (row_limit > ROW_LIMIT_MAX) ? ROW_LIMIT_MAX : row_limit;

  always_comb begin
    st_nxt  = st;
    res_vld = 1'b0;
    res     = '{character: CHAR_SPACE, cursor_column: st.col, cursor_row: st.row};
    col_w   = {1'b0, st.col};
    row_w   = {1'b0, st.row};
    if (scan_code == KEY_BREAK) begin
      st_nxt.brk = 1'b1;
    end else if (scan_code == KEY_EXT) begin
      st_nxt.ext = 1'b1;
    end else begin
      if (st.brk) begin
        st_nxt.brk = 1'b0;
        if (scan_code == KEY_RSHIFT) st_nxt.shr = 1'b0;
        else if (scan_code == KEY_LSHIFT) st_nxt.shl = 1'b0;
        if (scan_code == KEY_CTRL) begin
          if (st.ext) st_nxt.ctr = 1'b0;
          else st_nxt.ctl = 1'b0;
        end
      end else if (scan_code == KEY_LSHIFT) begin
        st_nxt.shl = 1'b1;
      end else if (scan_code == KEY_RSHIFT) begin
        st_nxt.shr = 1'b1;
      end else if (scan_code == KEY_CTRL) begin
        if (st.ext) st_nxt.ctr = 1'b1;
        else st_nxt.ctl = 1'b1;
      end else begin
        if (scan_code == KEY_BKSP) begin
          if (st.col != '0) col_w = {1'b0, st.col} - 1'b1;
          res_vld = 1'b1;
          res.character     = CHAR_SPACE;
          res.cursor_column = col_w[COL_W-1:0];
        end else if (scan_code == KEY_ENTER) begin
          row_w = {1'b0, st.row} + 1'b1;
          col_w = '0;
        end else if (scan_code == KEY_CAPS && !ctrl) begin
          st_nxt.caps = ~st.caps;
        end else if (km.hit) begin
          res_vld = 1'b1;
          res.character = km.ch;
          col_w = {1'b0, st.col} + 1'b1;
        end
        if (col_w >= clim) begin
          col_w = '0;
          row_w = row_w + 1'b1;
        end
        if (row_w >= rlim) row_w = '0;
        st_nxt.col = col_w[COL_W-1:0];
        st_nxt.row = row_w[ROW_W-1:0];
      end
      st_nxt.ext = 1'b0;
    end
  end

endmodule

>>> rtl/ps2_keyboard_to_text_cursor.sv
// Turns PS/2 set-2 scan code bytes into display writes of an ASCII character at a text
// cursor. One byte is taken per cycle while the write output is not stalled; each byte is
// held in the input register and its write, if any, then moves to the result register,
// from which it is offered on out_text.
// The keyboard state (break and extended prefixes, shifts, ctrls, caps lock, cursor) is
// updated by the combinational core between those registers. Bytes that cause no write
// still pass through the input register. Limits are written over cfg_wr, which is always
// ready; write them only while the block is idle.
module ps2_keyboard_to_text_cursor (
  input logic           clk,
  input logic           rst_n,
  ps2txt_scan_if.sink   in_scan,
  ps2txt_text_if.source out_text,
  ps2txt_cfg_if.sink    cfg_wr
);
  import ps2txt_pkg::*;

  logic              s1_valid_r;
  logic [SCAN_W-1:0] s1_code_r;
  kb_state_t         st_r;
  kb_state_t         st_nxt;
  logic              out_valid_r;
  text_res_t         out_res_r;
  logic [CLIM_W-1:0] col_limit_r;
  logic [RLIM_W-1:0] row_limit_r;
  logic              res_vld;
  text_res_t         res;
  logic              advance;
  logic              s1_fire;
  logic              in_fire;

  assign advance = ~out_valid_r | out_text.ready;
  assign s1_fire = s1_valid_r & advance;
  assign in_scan.ready = ~s1_valid_r | advance;
  assign in_fire = in_scan.valid & in_scan.ready;
  assign cfg_wr.ready = 1'b1;

  assign out_text.valid         = out_valid_r;
  assign out_text.character     = out_res_r.character;
  assign out_text.cursor_column = out_res_r.cursor_column;
  assign out_text.cursor_row    = out_res_r.cursor_row;

  ps2txt_core u_core (
    .scan_code (s1_code_r),
    .st        (st_r),
    .col_limit (col_limit_r),
    .row_limit (row_limit_r),
    .st_nxt    (st_nxt),
    .res_vld   (res_vld),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
      col_limit_r <= COL_LIMIT_RST;
      row_limit_r <= ROW_LIMIT_RST;
    end else begin
      if (in_fire) s1_valid_r <= 1'b1;
      else if (s1_fire) s1_valid_r <= 1'b0;
      if (advance) out_valid_r <= s1_fire & res_vld;
      if (s1_fire) st_r <= st_nxt;
      if (cfg_wr.valid) begin
        case (cfg_wr.index)
          CFG_COL_LIMIT: col_limit_r <= cfg_wr.data;
          CFG_ROW_LIMIT: row_limit_r <= cfg_wr.data[RLIM_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) s1_code_r <= in_scan.scan_code;
    if (s1_fire && res_vld) out_res_r <= res;
  end

  // the break prefix byte sets its flag
  a_break_set: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_code_r == KEY_BREAK |=> st_r.brk)
    else $error("break prefix not recorded");

  // extended prefix lasts for one key only
  a_ext_clear: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_code_r != KEY_BREAK && s1_code_r != KEY_EXT |=> !st_r.ext)
    else $error("extended prefix not cleared");

  // backspace make always writes a space
  a_bksp_space: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_code_r == KEY_BKSP && !st_r.brk |=>
      out_valid_r && out_res_r.character == CHAR_SPACE)
    else $error("backspace did not write a space");

endmodule

>>> tb/ps2_keyboard_to_text_cursor_tb.sv
`timescale 1ns / 1ps

module ps2_keyboard_to_text_cursor_tb;
  import ps2txt_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 210;

  localparam logic [0:25][7:0] LETTER_SC = {
    8'h1C, 8'h32, 8'h21, 8'h23, 8'h24, 8'h2B, 8'h34, 8'h33, 8'h43, 8'h3B, 8'h42, 8'h4B, 8'h3A,
    8'h31, 8'h44, 8'h4D, 8'h15, 8'h2D, 8'h1B, 8'h2C, 8'h3C, 8'h2A, 8'h1D, 8'h22, 8'h35, 8'h1A
  };
  localparam logic [0:20][7:0] SYMBOL_SC = {
    8'h45, 8'h16, 8'h1E, 8'h26, 8'h25, 8'h2E, 8'h36, 8'h3D, 8'h3E, 8'h46, 8'h52,
    8'h41, 8'h4E, 8'h49, 8'h4A, 8'h4C, 8'h55, 8'h54, 8'h5D, 8'h5B, 8'h0E
  };
  localparam logic [0:20][6:0] SYMBOL_PLAIN = {
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h27,
    7'h2C, 7'h2D, 7'h2E, 7'h2F, 7'h3B, 7'h3D, 7'h5B, 7'h5C, 7'h5D, 7'h60
  };
  localparam logic [0:20][6:0] SYMBOL_SHIFTED = {
    7'h29, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28, 7'h22,
    7'h3C, 7'h5F, 7'h3E, 7'h3F, 7'h3A, 7'h2B, 7'h7B, 7'h7C, 7'h7D, 7'h7E
  };
  localparam logic [0:6][7:0] CTRL_SC = {8'h1E, 8'h54, 8'h5D, 8'h5B, 8'h36, 8'h4E, 8'h4A};
  localparam logic [0:6][6:0] CTRL_CH = {7'h00, 7'h1B, 7'h1C, 7'h1D, 7'h1E, 7'h1F, 7'h7F};

  localparam logic [0:PHASES-1][7:0] COL_PLAN =
    {8'd128, 8'd1, 8'd0, 8'd255, 8'd5, 8'd17, 8'd128, 8'd2, 8'd80};
  localparam logic [0:PHASES-1][7:0] ROW_PLAN =
    {8'd64, 8'd1, 8'd0, 8'd255, 8'd3, 8'd4, 8'd2, 8'd64, 8'd40};
  localparam logic [0:PHASES-1][7:0] IDLE_PLAN =
    {8'd20, 8'd30, 8'd0, 8'd15, 8'd25, 8'd10, 8'd40, 8'd20, 8'd0};

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ps2txt_scan_if scan_if ();
  ps2txt_text_if text_if ();
  ps2txt_cfg_if  cfg_if ();

  ps2_keyboard_to_text_cursor u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_scan (scan_if),
    .out_text(text_if),
    .cfg_wr  (cfg_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [SCAN_W-1:0] scan_bytes[$];
  text_res_t         pending_writes[$];
  text_res_t         predicted;
  text_res_t         exp_wr;

  int n_queued    = 0;
  int n_taken     = 0;
  int n_errors    = 0;
  int quiet_count = 0;
  int idle_rate   = 15;
  int send_gap    = 0;
  int stall_left  = 0;
  bit scan_taken  = 1'b0;
  bit cfg_taken   = 1'b0;

  logic              break_seen = 1'b0;
  logic              ext_seen   = 1'b0;
  logic              shift_l    = 1'b0;
  logic              shift_r    = 1'b0;
  logic              ctrl_l     = 1'b0;
  logic              ctrl_r     = 1'b0;
  logic              caps_on    = 1'b0;
  logic [COL_W-1:0]  cur_col    = '0;
  logic [ROW_W-1:0]  cur_row    = '0;
  logic [CLIM_W-1:0] col_lim    = COL_LIMIT_RST;
  logic [RLIM_W-1:0] row_lim    = ROW_LIMIT_RST;

  function automatic bit next_text_write(input logic [SCAN_W-1:0] sc, output text_res_t wr);
    bit ctrl;
    bit shift;
    bit hit;
    logic [CHAR_W-1:0] ch;
    int col;
    int row;
    int climit;
    int rlimit;
    hit = 1'b0;
    ch  = '0;
    wr  = '0;
    if (sc == KEY_BREAK) begin
      break_seen = 1'b1;
      return 1'b0;
    end
    if (sc == KEY_EXT) begin
      ext_seen = 1'b1;
      return 1'b0;
    end
    col = cur_col;
    row = cur_row;
    if (break_seen) begin
      break_seen = 1'b0;
      if (sc == KEY_RSHIFT) shift_r = 1'b0;
      else if (sc == KEY_LSHIFT) shift_l = 1'b0;
      if (sc == KEY_CTRL) begin
        if (ext_seen) ctrl_r = 1'b0;
        else ctrl_l = 1'b0;
      end
    end else if (sc == KEY_LSHIFT) begin
      shift_l = 1'b1;
    end else if (sc == KEY_RSHIFT) begin
      shift_r = 1'b1;
    end else if (sc == KEY_CTRL) begin
      if (ext_seen) ctrl_r = 1'b1;
      else ctrl_l = 1'b1;
    end else begin
      ctrl  = ctrl_l || ctrl_r;
      shift = shift_l || shift_r;
      if (sc == KEY_BKSP) begin
        if (col > 0) col = col - 1;
        hit = 1'b1;
        ch  = CHAR_SPACE;
      end else if (sc == KEY_ENTER) begin
        row = row + 1;
        col = 0;
      end else if (sc == KEY_CAPS && !ctrl) begin
        caps_on = !caps_on;
      end else if (ctrl) begin
        for (int i = 0; i < 26; i++)
          if (LETTER_SC[i] == sc) begin
            hit = 1'b1;
            ch  = CHAR_W'(i + 1);
          end
        for (int i = 0; i < 7; i++)
          if (CTRL_SC[i] == sc) begin
            hit = 1'b1;
            ch  = CTRL_CH[i];
          end
      end else begin
        for (int i = 0; i < 26; i++)
          if (LETTER_SC[i] == sc) begin
            hit = 1'b1;
            ch  = ((shift != caps_on) ? CHAR_UPPER : CHAR_LOWER) + CHAR_W'(i);
          end
        for (int i = 0; i < 21; i++)
          if (SYMBOL_SC[i] == sc) begin
            hit = 1'b1;
            ch  = shift ? SYMBOL_SHIFTED[i] : SYMBOL_PLAIN[i];
          end
        if (sc == KEY_SPACE) begin
          hit = 1'b1;
          ch  = CHAR_SPACE;
        end else if (sc == KEY_TAB) begin
          hit = 1'b1;
          ch  = CHAR_TAB;
        end else if (sc == KEY_ESC) begin
          hit = 1'b1;
          ch  = CHAR_ESC;
        end else if (sc == KEY_DEL && ext_seen) begin
          hit = 1'b1;
          ch  = CHAR_DEL;
        end
      end
      if (hit) begin
        wr.character     = ch;
        wr.cursor_column = COL_W'(col);
        wr.cursor_row    = ROW_W'(row);
        if (sc != KEY_BKSP) col = col + 1;
      end
      climit = (col_lim > COL_LIMIT_MAX) ? COL_LIMIT_MAX : col_lim;
      rlimit = (row_lim > ROW_LIMIT_MAX) ? ROW_LIMIT_MAX : row_lim;
      if (col >= climit) begin
        col = 0;
        row = row + 1;
      end
      if (row >= rlimit) row = 0;
      cur_col = COL_W'(col);
      cur_row = ROW_W'(row);
    end
    ext_seen = 1'b0;
    return hit;
  endfunction

  // drive scan bytes, with random gaps between transfers
  always @(negedge clk) begin
    if (!rst_n) begin
      scan_if.valid <= 1'b0;
      send_gap      <= 0;
    end else if (!scan_if.valid || scan_taken) begin
      if (send_gap != 0) begin
        scan_if.valid <= 1'b0;
        send_gap      <= send_gap - 1;
      end else if (scan_bytes.size() == 0) begin
        scan_if.valid <= 1'b0;
      end else if (idle_rate != 0 && $urandom_range(0, 99) < idle_rate) begin
        scan_if.valid <= 1'b0;
        send_gap      <= $urandom_range(0, 7);
      end else begin
        scan_if.valid     <= 1'b1;
        scan_if.scan_code <= scan_bytes.pop_front();
      end
    end
  end

  // stall the write channel in random bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      text_if.ready <= 1'b0;
      stall_left    <= 0;
    end else if (stall_left != 0) begin
      text_if.ready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (idle_rate != 0 && $urandom_range(0, 99) < idle_rate) begin
      text_if.ready <= 1'b0;
      stall_left    <= $urandom_range(0, 7);
    end else begin
      text_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    scan_taken = rst_n && scan_if.valid && scan_if.ready;
    cfg_taken  = rst_n && cfg_if.valid && cfg_if.ready;
    if (rst_n) begin
      quiet_count = quiet_count + 1;
      if (cfg_taken) begin
        quiet_count = 0;
        case (cfg_if.index)
          CFG_COL_LIMIT: col_lim = cfg_if.data;
          CFG_ROW_LIMIT: row_lim = cfg_if.data[RLIM_W-1:0];
          default: ;
        endcase
      end
      if (scan_taken) begin
        quiet_count = 0;
        n_taken     = n_taken + 1;
        if (next_text_write(scan_if.scan_code, predicted)) pending_writes.push_back(predicted);
      end
      if (text_if.valid && text_if.ready) begin
        quiet_count = 0;
        if (pending_writes.size() == 0) begin
          n_errors = n_errors + 1;
          if (n_errors <= 40)
            $display("%0t: unexpected write, expected none, actual char %h col %0d row %0d",
                     $time, text_if.character, text_if.cursor_column, text_if.cursor_row);
        end else begin
          exp_wr = pending_writes.pop_front();
          if (text_if.character !== exp_wr.character) begin
            n_errors = n_errors + 1;
            if (n_errors <= 40)
              $display("%0t: character expected %h actual %h", $time,
                       exp_wr.character, text_if.character);
          end
          if (text_if.cursor_column !== exp_wr.cursor_column) begin
            n_errors = n_errors + 1;
            if (n_errors <= 40)
              $display("%0t: cursor_column expected %0d actual %0d", $time,
                       exp_wr.cursor_column, text_if.cursor_column);
          end
          if (text_if.cursor_row !== exp_wr.cursor_row) begin
            n_errors = n_errors + 1;
            if (n_errors <= 40)
              $display("%0t: cursor_row expected %0d actual %0d", $time,
                       exp_wr.cursor_row, text_if.cursor_row);
          end
        end
      end
      if (quiet_count >= QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("ps2_keyboard_to_text_cursor regression: fail");
        $finish;
      end
    end
  end

  task automatic push_scan(input logic [SCAN_W-1:0] b);
    scan_bytes.push_back(b);
    n_queued = n_queued + 1;
  endtask

  task automatic drain_writes;
    do @(negedge clk); while (n_taken != n_queued || pending_writes.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(negedge clk); while (!cfg_taken);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic queue_random_keys(input int n);
    int start;
    int pick;
    logic [SCAN_W-1:0] key;
    start = n_queued;
    while (n_queued - start < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        case ($urandom_range(0, 5))
          0, 1, 2: key = LETTER_SC[$urandom_range(0, 25)];
          3, 4:    key = SYMBOL_SC[$urandom_range(0, 20)];
          default: key = ($urandom_range(0, 2) == 0) ? KEY_SPACE :
                         ($urandom_range(0, 1) ? KEY_TAB : KEY_ESC);
        endcase
        if ($urandom_range(0, 9) == 0) push_scan(KEY_EXT);
        push_scan(key);
        if ($urandom_range(0, 1)) begin
          push_scan(KEY_BREAK);
          push_scan(key);
        end
      end else if (pick < 60) begin
        key = $urandom_range(0, 1) ? KEY_CTRL : ($urandom_range(0, 1) ? KEY_LSHIFT : KEY_RSHIFT);
        if ($urandom_range(0, 1)) push_scan(KEY_EXT);
        if ($urandom_range(0, 99) < 60) push_scan(KEY_BREAK);
        push_scan(key);
      end else if (pick < 66) begin
        push_scan(KEY_CAPS);
        push_scan(KEY_BREAK);
        push_scan(KEY_CAPS);
      end else if (pick < 74) begin
        push_scan(KEY_BKSP);
      end else if (pick < 80) begin
        push_scan(KEY_ENTER);
      end else if (pick < 85) begin
        push_scan(KEY_EXT);
        push_scan(KEY_DEL);
      end else if (pick < 88) begin
        push_scan(KEY_DEL);
      end else begin
        push_scan(SCAN_W'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    scan_if.valid     = 1'b0;
    scan_if.scan_code = '0;
    text_if.ready     = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = '0;
    cfg_if.data       = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // letters, shift, caps, ctrl, right ctrl, delete, cursor edges
    push_scan(8'h1C);
    push_scan(KEY_LSHIFT);
    push_scan(8'h1C);
    push_scan(KEY_BREAK);
    push_scan(KEY_LSHIFT);
    push_scan(KEY_CAPS);
    push_scan(KEY_RSHIFT);
    push_scan(8'h1A);
    push_scan(8'h0E);
    push_scan(KEY_BREAK);
    push_scan(KEY_RSHIFT);
    push_scan(KEY_CTRL);
    push_scan(8'h1C);
    push_scan(KEY_CAPS);
    push_scan(KEY_BKSP);
    push_scan(KEY_BREAK);
    push_scan(KEY_CTRL);
    push_scan(KEY_EXT);
    push_scan(KEY_CTRL);
    push_scan(8'h4A);
    push_scan(KEY_EXT);
    push_scan(KEY_BREAK);
    push_scan(KEY_CTRL);
    push_scan(KEY_EXT);
    push_scan(KEY_DEL);
    push_scan(KEY_DEL);
    push_scan(KEY_SPACE);
    push_scan(KEY_ENTER);
    push_scan(KEY_BKSP);
    push_scan(8'hFF);
    push_scan(8'h00);
    drain_writes();

    for (int p = 0; p < PHASES; p++) begin
      write_limit(CFG_COL_LIMIT, COL_PLAN[p]);
      write_limit(CFG_ROW_LIMIT, ROW_PLAN[p]);
      idle_rate = IDLE_PLAN[p];
      queue_random_keys(PHASE_ITEMS);
      drain_writes();
    end

    if (n_errors == 0) begin
      $display("ps2_keyboard_to_text_cursor regression: pass");
    end else begin
      $display("ps2_keyboard_to_text_cursor regression: fail");
    end
    $finish;
  end

endmodule

>>> ps2_keyboard_to_text_cursor.f
rtl/ps2txt_pkg.sv
rtl/ps2txt_ifs.sv
rtl/ps2txt_core.sv
rtl/ps2_keyboard_to_text_cursor.sv
tb/ps2_keyboard_to_text_cursor_tb.sv
